// ===== rtl/exp_breakpoint_curve_eval_core_macros.svh =====
// assertion helpers shared by the checker
`ifndef EXP_BREAKPOINT_CURVE_EVAL_CORE_MACROS_SVH
`define EXP_BREAKPOINT_CURVE_EVAL_CORE_MACROS_SVH

// same-cycle implication
`define EBC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ebc check failed");

// next-cycle implication
`define EBC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("ebc check failed");

`endif

// ===== rtl/ebc_pkg.sv =====
package ebc_pkg;

  localparam int unsigned EBC_POINTS = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned FRAC       = 15;
  localparam int unsigned DVD_W      = 56;
  localparam int unsigned DVS_W      = 40;
  localparam int unsigned DIV_CNT_W  = $clog2(DVD_W + 1);
  localparam int unsigned CNT_MIN    = 2;

  localparam logic [DATA_W-1:0] ONE       = 16'h8000;
  localparam logic [DATA_W-1:0] LIN_LIMIT = 16'd20;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  localparam logic [1:0] REG_POINT_COUNT = 2'd0;

  // floor(2^32 / k) for the taylor term divide, k = 2..25
  localparam logic [31:0] EBC_RECIP [32] = '{
    32'd0, 32'd0,
    32'(33'h100000000 / 2),  32'(33'h100000000 / 3),  32'(33'h100000000 / 4),
    32'(33'h100000000 / 5),  32'(33'h100000000 / 6),  32'(33'h100000000 / 7),
    32'(33'h100000000 / 8),  32'(33'h100000000 / 9),  32'(33'h100000000 / 10),
    32'(33'h100000000 / 11), 32'(33'h100000000 / 12), 32'(33'h100000000 / 13),
    32'(33'h100000000 / 14), 32'(33'h100000000 / 15), 32'(33'h100000000 / 16),
    32'(33'h100000000 / 17), 32'(33'h100000000 / 18), 32'(33'h100000000 / 19),
    32'(33'h100000000 / 20), 32'(33'h100000000 / 21), 32'(33'h100000000 / 22),
    32'(33'h100000000 / 23), 32'(33'h100000000 / 24), 32'(33'h100000000 / 25),
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef struct packed {
    logic                     func;
    logic [IDX_W-1:0]         point_index;
    logic [DATA_W-1:0]        point_x;
    logic [DATA_W-1:0]        point_y;
    logic signed [DATA_W-1:0] point_power;
    logic [DATA_W-1:0]        sample_x;
  } ebc_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] curve_value;
    logic [IDX_W-1:0]  segment_index;
    logic              found;
  } ebc_out_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] p;
  } ebc_wr_t;

  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [IDX_W-1:0]  seg;
    logic [DATA_W-1:0] sx;
    logic [DATA_W-1:0] x0;
    logic [DATA_W-1:0] x1;
    logic [DATA_W-1:0] y0;
    logic [DATA_W-1:0] y1;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] ylast;
  } ebc_tok_t;

  typedef struct packed {
    logic [DATA_W-1:0] dx;
    logic [DATA_W-1:0] width;
    logic [DATA_W-1:0] y0;
    logic [DATA_W-1:0] y1;
    logic [DATA_W-1:0] p;
  } ebc_seg_t;

endpackage

// ===== rtl/ebc_cell.sv =====
module ebc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [ebc_pkg::IDX_W-1:0]  cell_idx,
  input  logic [ebc_pkg::CNT_W-1:0]  n_use,
  input  ebc_pkg::ebc_wr_t         wr,
  input  ebc_pkg::ebc_tok_t        tok_i,
  input  logic [ebc_pkg::DATA_W-1:0] x_nxt_i,
  input  logic [ebc_pkg::DATA_W-1:0] y_nxt_i,
  output ebc_pkg::ebc_tok_t        tok_o,
  output logic [ebc_pkg::DATA_W-1:0] x_o,
  output logic [ebc_pkg::DATA_W-1:0] y_o
);
  import ebc_pkg::*;

  logic [DATA_W-1:0] x_r, y_r, p_r;
  ebc_tok_t          tok_r, tok_nxt;
  logic [CNT_W-1:0]  pos_nxt;

  assign pos_nxt = CNT_W'(cell_idx) + CNT_W'(1);

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.vld && !tok_i.hit && (pos_nxt < n_use) &&
        (tok_i.sx >= x_r) && (tok_i.sx <= x_nxt_i)) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.seg = cell_idx;
      tok_nxt.x0  = x_r;
      tok_nxt.x1  = x_nxt_i;
      tok_nxt.y0  = y_r;
      tok_nxt.y1  = y_nxt_i;
      tok_nxt.p   = p_r;
    end
    // last point in use
    if (pos_nxt == n_use) begin
      tok_nxt.ylast = y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= (cell_idx == IDX_W'(1)) ? ONE : '0;
      y_r   <= (cell_idx == IDX_W'(0)) ? ONE : '0;
      p_r   <= '0;
      tok_r <= '0;
    end else begin
      if (wr.en && (wr.idx == cell_idx)) begin
        x_r <= wr.x;
        y_r <= wr.y;
        p_r <= wr.p;
      end
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;
  assign x_o   = x_r;
  assign y_o   = y_r;

endmodule

// ===== rtl/ebc_div.sv =====
module ebc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ebc_pkg::DVD_W-1:0] dividend,
  input  logic [ebc_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [ebc_pkg::DVD_W-1:0] quotient
);
  import ebc_pkg::*;

  logic [DVS_W-1:0]     rem_r, dvs_r;
  logic [DVD_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DVS_W:0]       trial;
  logic                 ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
        cnt_r <= DIV_CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        rem_r <= ge ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
        quo_r <= {quo_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/ebc_arith.sv =====
module ebc_arith (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  ebc_pkg::ebc_seg_t          req,
  output logic                       done,
  output logic [ebc_pkg::DATA_W-1:0] value
);
  import ebc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LMUL, S_LDIV, S_LWAIT, S_TDIV, S_TWAIT, S_QT, S_EXPI,
    S_TAY, S_RCP, S_FIX, S_DA, S_DB, S_DC, S_DD, S_EXPD,
    S_FDIV, S_FWAIT, S_HMUL, S_FIN
  } state_t;

  state_t            state_r;
  ebc_seg_t          req_r;
  logic [DATA_W-1:0] hmag_r, q_r, tt_r, f_r, value_r;
  logic              hneg_r, pneg_r, phase_r, done_r;
  logic [26:0]       r_r, term_r;
  logic [39:0]       sum_r, num_r;
  logic [4:0]        k_r;
  logic [27:0]       x_r;
  logic [55:0]       acc_r;
  logic [1:0]        dbl_r;
  logic [63:0]       mul_r;
  logic [31:0]       mul_a, mul_b;

  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_quo;
  logic [DVS_W-1:0]  div_dvs;

  logic [DATA_W-1:0] pabs, hmag_in, tq, fq;
  logic signed [DATA_W-1:0] ps;
  logic              lin;
  logic [27:0]       q0;
  logic [32:0]       rem;
  logic [55:0]       dbl_acc;
  logic [17:0]       rnd;
  logic signed [18:0] v, lo, hi;

  ebc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign ps      = $signed(req.p);
  assign pabs    = req.p[DATA_W-1] ? (~req.p + 16'd1) : req.p;
  assign lin     = (ps >= -$signed(LIN_LIMIT)) && (ps <= $signed(LIN_LIMIT));
  assign hmag_in = (req.y1 < req.y0) ? (req.y0 - req.y1) : (req.y1 - req.y0);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LMUL: begin mul_a = 32'(req_r.dx); mul_b = 32'(hmag_r); end
      S_QT:   begin mul_a = 32'(q_r);      mul_b = 32'(tt_r);   end
      S_TAY:  begin mul_a = 32'(term_r);   mul_b = 32'(r_r);    end
      S_RCP:  begin mul_a = 32'(mul_r[53:26]); mul_b = EBC_RECIP[k_r]; end
      S_DA:   begin mul_a = 32'(sum_r[25:0]);  mul_b = 32'(sum_r[25:0]); end
      S_DB:   begin mul_a = 32'(sum_r[39:26]); mul_b = 32'(sum_r[25:0]); end
      S_DC:   begin mul_a = 32'(sum_r[39:26]); mul_b = 32'(sum_r[39:26]); end
      S_HMUL: begin mul_a = 32'(f_r);      mul_b = 32'(hmag_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_r)
      S_LDIV: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(mul_r[31:0]) + DVD_W'(req_r.width >> 1);
        div_dvs   = DVS_W'(req_r.width);
      end
      S_TDIV: begin
        div_start = 1'b1;
        div_dvd   = (DVD_W'(req_r.dx) << FRAC) + DVD_W'(req_r.width >> 1);
        div_dvs   = DVS_W'(req_r.width);
      end
      S_FDIV: begin
        div_start = 1'b1;
        div_dvd   = (DVD_W'(num_r) << FRAC) + DVD_W'(sum_r >> 1);
        div_dvs   = sum_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign tq      = (div_quo > DVD_W'(ONE)) ? ONE : div_quo[DATA_W-1:0];
  assign fq      = div_quo[DATA_W-1:0];
  assign q0      = mul_r[59:32];
  assign rem     = 33'(x_r) - 33'(q0) * 33'(k_r);
  assign dbl_acc = acc_r + (56'(mul_r[27:0]) << 26);
  assign rnd     = 18'((mul_r[32:0] + 33'h4000) >> FRAC);
  assign v       = hneg_r ? (19'(req_r.y0) - 19'(rnd)) : (19'(req_r.y0) + 19'(rnd));
  assign lo      = hneg_r ? 19'(req_r.y1) : 19'(req_r.y0);
  assign hi      = hneg_r ? 19'(req_r.y0) : 19'(req_r.y1);

  always_ff @(posedge clk) begin
    mul_r <= 64'(mul_a) * 64'(mul_b);
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r   <= req;
            hmag_r  <= hmag_in;
            hneg_r  <= req.y1 < req.y0;
            pneg_r  <= req.p[DATA_W-1];
            q_r     <= pabs;
            state_r <= lin ? S_LMUL : S_TDIV;
          end
        end
        S_LMUL:  state_r <= S_LDIV;
        S_LDIV:  state_r <= S_LWAIT;
        S_LWAIT: begin
          if (div_done) begin
            value_r <= hneg_r ? (req_r.y0 - fq) : (req_r.y0 + fq);
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_TDIV:  state_r <= S_TWAIT;
        S_TWAIT: begin
          if (div_done) begin
            tt_r    <= pneg_r ? (ONE - tq) : tq;
            state_r <= S_QT;
          end
        end
        S_QT:    state_r <= S_EXPI;
        S_EXPI: begin
          // argument scaled by 1/8, q.26
          r_r     <= mul_r[30:4];
          term_r  <= mul_r[30:4];
          sum_r   <= '0;
          k_r     <= 5'd2;
          phase_r <= 1'b0;
          state_r <= S_TAY;
        end
        S_TAY: begin
          if (k_r == 5'd26 || term_r == '0) begin
            dbl_r   <= '0;
            state_r <= S_DA;
          end else begin
            sum_r   <= sum_r + 40'(term_r);
            state_r <= S_RCP;
          end
        end
        S_RCP: begin
          x_r     <= mul_r[53:26];
          state_r <= S_FIX;
        end
        S_FIX: begin
          // reciprocal estimate is at most one low
          term_r  <= (rem >= 33'(k_r)) ? 27'(q0 + 28'd1) : 27'(q0);
          k_r     <= k_r + 5'd1;
          state_r <= S_TAY;
        end
        S_DA: state_r <= S_DB;
        S_DB: begin
          acc_r   <= 56'(mul_r[51:26]);
          state_r <= S_DC;
        end
        S_DC: begin
          acc_r   <= acc_r + (56'(mul_r[40:0]) << 1);
          state_r <= S_DD;
        end
        S_DD: begin
          sum_r   <= 40'((56'(sum_r) << 1) + dbl_acc);
          dbl_r   <= dbl_r + 2'd1;
          state_r <= (dbl_r == 2'd2) ? S_EXPD : S_DA;
        end
        S_EXPD: begin
          if (!phase_r) begin
            num_r   <= sum_r;
            r_r     <= 27'(q_r) << 11;
            term_r  <= 27'(q_r) << 11;
            sum_r   <= '0;
            k_r     <= 5'd2;
            phase_r <= 1'b1;
            state_r <= S_TAY;
          end else if (sum_r == '0) begin
            f_r     <= pneg_r ? (ONE - tt_r) : tt_r;
            state_r <= S_HMUL;
          end else begin
            state_r <= S_FDIV;
          end
        end
        S_FDIV:  state_r <= S_FWAIT;
        S_FWAIT: begin
          if (div_done) begin
            f_r     <= pneg_r ? (ONE - fq) : fq;
            state_r <= S_HMUL;
          end
        end
        S_HMUL:  state_r <= S_FIN;
        S_FIN: begin
          if (v < lo) begin
            value_r <= DATA_W'(lo);
          end else if (v > hi) begin
            value_r <= DATA_W'(hi);
          end else begin
            value_r <= DATA_W'(v);
          end
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign value = value_r;

endmodule

// ===== rtl/exp_breakpoint_curve_eval_core.sv =====
// channel  | handshake              | word
// ---------+------------------------+---------------------------------
// input    | start / busy           | in_word  (ebc_in_t)
// result   | out_valid strobe       | out_word (ebc_out_t)
// config   | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// a write word is taken and its result strobes on the next cycle
// an evaluate word walks the 16-cell breakpoint row and resolves at once,
// or runs the shared exp/divide unit: one 56-step restoring divide for a
// straight segment; for a curved one, taylor sums of up to 24 terms, run
// twice, and up to two 56-step restoring divides
// synchronous reset on rst_n restores two default points; results never stall
module exp_breakpoint_curve_eval_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ebc_pkg::ebc_in_t  in_word,
  output logic              out_valid,
  output ebc_pkg::ebc_out_t out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ebc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_ARITH} state_t;

  state_t            state_r;
  logic              out_valid_r;
  ebc_out_t          out_word_r;
  logic [CNT_W-1:0]  pc_r;
  logic [IDX_W-1:0]  seg_r;
  logic              hit_r;

  logic              accept;
  logic [CNT_W-1:0]  n_use;
  ebc_wr_t           wr;
  ebc_tok_t          tok [EBC_POINTS+1];
  logic [DATA_W-1:0] cx [EBC_POINTS];
  logic [DATA_W-1:0] cy [EBC_POINTS];
  ebc_tok_t          tl;
  logic              ar_start, ar_done;
  logic [DATA_W-1:0] ar_value;
  ebc_seg_t          ar_req;

  assign accept = start && !busy;
  assign busy   = state_r != S_IDLE;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_POINT_COUNT) ? 32'(pc_r) : '0;

  // point count clamped to 2..16
  assign n_use = (pc_r < CNT_W'(CNT_MIN)) ? CNT_W'(CNT_MIN) :
                 (pc_r > CNT_W'(EBC_POINTS)) ? CNT_W'(EBC_POINTS) : pc_r;

  // breakpoint write broadcast to the row
  assign wr.en  = accept && (in_word.func == FUNC_WRITE);
  assign wr.idx = in_word.point_index;
  assign wr.x   = in_word.point_x;
  assign wr.y   = in_word.point_y;
  assign wr.p   = in_word.point_power;

  // search token enters cell 0
  always_comb begin
    tok[0]     = '0;
    tok[0].vld = accept && (in_word.func == FUNC_EVAL);
    tok[0].sx  = in_word.sample_x;
  end

  for (genvar i = 0; i < EBC_POINTS; i++) begin : g_cell
    logic [DATA_W-1:0] xn, yn;
    if (i < EBC_POINTS - 1) begin : g_mid
      assign xn = cx[i+1];
      assign yn = cy[i+1];
    end else begin : g_end
      assign xn = '0;
      assign yn = '0;
    end
    ebc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .n_use    (n_use),
      .wr       (wr),
      .tok_i    (tok[i]),
      .x_nxt_i  (xn),
      .y_nxt_i  (yn),
      .tok_o    (tok[i+1]),
      .x_o      (cx[i]),
      .y_o      (cy[i])
    );
  end

  assign tl = tok[EBC_POINTS];

  // interior point of a real segment goes to the arithmetic unit
  assign ar_start = (state_r == S_SEARCH) && tl.vld && (tl.sx != '0) &&
                    (tl.sx != ONE) && tl.hit && (tl.x0 != tl.x1) &&
                    (tl.sx != tl.x1) && (tl.sx != tl.x0);
  assign ar_req.dx    = tl.sx - tl.x0;
  assign ar_req.width = tl.x1 - tl.x0;
  assign ar_req.y0    = tl.y0;
  assign ar_req.y1    = tl.y1;
  assign ar_req.p     = tl.p;

  ebc_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ar_start),
    .req   (ar_req),
    .done  (ar_done),
    .value (ar_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= CNT_W'(CNT_MIN);
    end else begin
      out_valid_r <= 1'b0;
      if (psel && penable && pwrite && pready && (paddr == REG_POINT_COUNT)) begin
        pc_r <= pwdata[CNT_W-1:0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_word.func == FUNC_WRITE) begin
              out_valid_r              <= 1'b1;
              out_word_r.curve_value   <= '0;
              out_word_r.segment_index <= '0;
              out_word_r.found         <= 1'b1;
            end else begin
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (tl.vld) begin
            seg_r <= tl.seg;
            hit_r <= tl.hit;
            out_word_r.segment_index <= tl.seg;
            out_word_r.found         <= tl.hit;
            if (ar_start) begin
              state_r <= S_ARITH;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
              priority if (tl.sx == '0) begin
                out_word_r.curve_value <= cy[0];
              end else if (tl.sx == ONE) begin
                out_word_r.curve_value <= tl.ylast;
              end else if (!tl.hit) begin
                out_word_r.curve_value <= '0;
              end else if ((tl.x0 == tl.x1) || (tl.sx == tl.x1)) begin
                out_word_r.curve_value <= tl.y1;
              end else begin
                out_word_r.curve_value <= tl.y0;
              end
            end
          end
        end
        S_ARITH: begin
          if (ar_done) begin
            out_valid_r              <= 1'b1;
            out_word_r.curve_value   <= ar_value;
            out_word_r.segment_index <= seg_r;
            out_word_r.found         <= hit_r;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/ebc_checker.sv =====
`include "exp_breakpoint_curve_eval_core_macros.svh"

module ebc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input ebc_pkg::ebc_in_t  in_word,
  input logic              out_valid,
  input ebc_pkg::ebc_out_t out_word,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [1:0]        paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);
  import ebc_pkg::*;

  // a write word answers on the next cycle with found set
  `EBC_ASSERT_NXT(a_write_ack, clk, rst_n, start && !busy && in_word.func == FUNC_WRITE, out_valid && out_word.found)
  // an evaluate word always goes through the search row
  `EBC_ASSERT_NXT(a_eval_busy, clk, rst_n, start && !busy && in_word.func == FUNC_EVAL, busy && !out_valid)
  // a result never shows while an evaluation is still open
  `EBC_ASSERT_IMP(a_out_idle, clk, rst_n, out_valid, !busy)
  // a nonzero segment index only comes with a bracketing hit
  `EBC_ASSERT_IMP(a_seg_found, clk, rst_n, out_valid && out_word.segment_index != '0, out_word.found)

endmodule

bind exp_breakpoint_curve_eval_core ebc_checker u_ebc_checker (.*);
